### rtl/core/sdtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdtc_pkg;

   localparam int CHARS_W    = 64;
   localparam int LEN_W      = 4;
   localparam int TOL_W      = 22;
   localparam int DAY_W      = 23;
   localparam int DOE_W      = 18;
   localparam int ERA_DAYS_W = 22;

   localparam logic [DOE_W-1:0] DAYS_PER_ERA = 18'd146097;
   localparam logic [DAY_W-1:0] EPOCH_SHIFT  = 23'd719468;

   // Parsed stamp: year split in hundreds and units, month and day already
   // defaulted to 1 when the stamp is too short to carry them.
   typedef struct packed {
      logic       ok;
      logic [6:0] hi;
      logic [6:0] lo;
      logic [3:0] month;
      logic [4:0] dom;
   } stamp_type;

   // Load enables of the day-number stages.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   // Days before the first of a month in a March-based year.
   function automatic logic [8:0] month_offset(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sdtc_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module sdtc_parse (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [sdtc_pkg::CHARS_W-1:0] chars,
   input  wire logic [sdtc_pkg::LEN_W-1:0]   length,
   output sdtc_pkg::stamp_type               stamp
);

   logic [7:0]          ch     [8];
   logic [7:0]          is_dig;
   logic [3:0]          val    [8];
   logic [6:0]          hi_val;
   logic [6:0]          lo_val;
   logic [6:0]          month_raw;
   logic [6:0]          dom_raw;
   logic                year_ok;
   logic                month_ok;
   logic                dom_ok;
   sdtc_pkg::stamp_type stamp_in;
   sdtc_pkg::stamp_type stamp_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         ch[i]     = chars[sdtc_pkg::CHARS_W-1-8*i -: 8];
         is_dig[i] = (ch[i] >= 8'h30) && (ch[i] <= 8'h39);
         val[i]    = ch[i][3:0];
      end
      hi_val    = {3'b000, val[0]} * 7'd10 + {3'b000, val[1]};
      lo_val    = {3'b000, val[2]} * 7'd10 + {3'b000, val[3]};
      month_raw = {3'b000, val[4]} * 7'd10 + {3'b000, val[5]};
      dom_raw   = {3'b000, val[6]} * 7'd10 + {3'b000, val[7]};

      year_ok  = (&is_dig[3:0]) && ((hi_val != 7'd0) || (lo_val != 7'd0));
      month_ok = (length < 4'd6) ||
                 (is_dig[4] && is_dig[5] && (month_raw >= 7'd1) && (month_raw <= 7'd12));
      dom_ok   = (length < 4'd8) ||
                 (is_dig[6] && is_dig[7] && (dom_raw >= 7'd1) && (dom_raw <= 7'd31));

      stamp_in.ok    = (length >= 4'd4) && year_ok && month_ok && dom_ok;
      stamp_in.hi    = hi_val;
      stamp_in.lo    = lo_val;
      stamp_in.month = (length >= 4'd6) ? month_raw[3:0] : 4'd1;
      stamp_in.dom   = (length >= 4'd8) ? dom_raw[4:0] : 5'd1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stamp_ff <= stamp_in;
      end
   end

   assign stamp = stamp_ff;

endmodule

`default_nettype wire

### rtl/core/sdtc_civil.sv
`timescale 1ns / 1ps
`default_nettype none

module sdtc_civil (
   input  wire logic                       clock,
   input  wire sdtc_pkg::stage_en_type     en,
   input  wire sdtc_pkg::stamp_type        stamp,
   output logic                            ok,
   output logic [sdtc_pkg::DAY_W-1:0]      day
);

   // stage 2: shift to a March-based year, split into era and year of era
   logic       mle2;
   logic [6:0] hi_adj;
   logic [6:0] lo_adj;
   logic [3:0] mp;
   logic       ok2_in,   ok2_ff;
   logic [4:0] era2_in,  era2_ff;
   logic [8:0] yoe2_in,  yoe2_ff;
   logic [1:0] cent2_in, cent2_ff;
   logic [8:0] doy2_in,  doy2_ff;

   // stage 3: day of era and era offset
   logic                               ok3_ff;
   logic [sdtc_pkg::DOE_W-1:0]         doe3_in, doe3_ff;
   logic [sdtc_pkg::ERA_DAYS_W-1:0]    era_days3_in, era_days3_ff;

   // stage 4: day number from the epoch
   logic                               ok4_ff;
   logic [sdtc_pkg::DAY_W-1:0]         day4_in, day4_ff;

   always_comb begin
      mle2   = stamp.month <= 4'd2;
      hi_adj = stamp.hi;
      lo_adj = stamp.lo;
      if (mle2) begin
         if (stamp.lo == 7'd0) begin
            lo_adj = 7'd99;
            hi_adj = stamp.hi - 7'd1;
         end else begin
            lo_adj = stamp.lo - 7'd1;
         end
      end
      mp       = mle2 ? (stamp.month + 4'd9) : (stamp.month - 4'd3);
      ok2_in   = stamp.ok;
      era2_in  = hi_adj[6:2];
      cent2_in = hi_adj[1:0];
      yoe2_in  = {7'd0, hi_adj[1:0]} * 9'd100 + {2'b00, lo_adj};
      doy2_in  = sdtc_pkg::month_offset(mp) + {4'd0, stamp.dom} - 9'd1;
   end

   always_comb begin
      doe3_in = {9'd0, yoe2_ff} * 18'd365
              + {11'd0, yoe2_ff[8:2]}
              - {16'd0, cent2_ff}
              + {9'd0, doy2_ff};
      era_days3_in = {17'd0, era2_ff} * {4'd0, sdtc_pkg::DAYS_PER_ERA};
   end

   always_comb begin
      if (ok3_ff) begin
         day4_in = {1'b0, era_days3_ff} + {5'd0, doe3_ff} - sdtc_pkg::EPOCH_SHIFT;
      end else begin
         day4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         ok2_ff   <= ok2_in;
         era2_ff  <= era2_in;
         yoe2_ff  <= yoe2_in;
         cent2_ff <= cent2_in;
         doy2_ff  <= doy2_in;
      end
      if (en.s3) begin
         ok3_ff       <= ok2_ff;
         doe3_ff      <= doe3_in;
         era_days3_ff <= era_days3_in;
      end
      if (en.s4) begin
         ok4_ff  <= ok3_ff;
         day4_ff <= day4_in;
      end
   end

   assign ok  = ok4_ff;
   assign day = day4_ff;

endmodule

`default_nettype wire

### rtl/core/snapshot_date_tolerance_check_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Snapshot date tolerance check. Each request word carries two ASCII date
// stamps (target and snapshot, YYYY, YYYYMM or YYYYMMDD, first character in
// the top byte, with a character count). Both are turned into proleptic
// Gregorian day numbers counted from 1970-01-01, and the response word tells
// whether the snapshot is newer than the target by no more than the
// tolerance held in the csr register. A zero tolerance, an invalid stamp, a
// pre-1970 date or a snapshot that is not newer always gives accepted = 1.
// Invalid stamps report ok = 0 and a day number of zero.
// Rate: one word per clock cycle while rsp_ready stays high. Five register
// stages carry each word from request to response: digit parse, March-year
// split, day-of-era multiply, epoch offset, and the compare stage that is
// also the response register. Each stage holds its word only while the
// stage ahead of it is full and stalled, so a stall of rsp_ready backs up
// through the pipe without dropping or repeating words.
// Write the tolerance only while no word is in flight.

module snapshot_date_tolerance_check_core (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [sdtc_pkg::CHARS_W-1:0] req_target_chars,
   input  wire logic [sdtc_pkg::LEN_W-1:0]   req_target_length,
   input  wire logic [sdtc_pkg::CHARS_W-1:0] req_snapshot_chars,
   input  wire logic [sdtc_pkg::LEN_W-1:0]   req_snapshot_length,

   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_target_ok,
   output logic                              rsp_snapshot_ok,
   output logic signed [sdtc_pkg::DAY_W-1:0] rsp_target_day,
   output logic signed [sdtc_pkg::DAY_W-1:0] rsp_snapshot_day,

   input  wire logic                         csr_write_enable,
   input  wire logic [sdtc_pkg::TOL_W-1:0]   csr_write_data
);

   // valid bit of each stage; stage 5 is the response register
   logic [5:1] valid_in, valid_ff;
   logic [5:1] load;

   logic [sdtc_pkg::TOL_W-1:0] tolerance_in, tolerance_ff;

   sdtc_pkg::stamp_type    target_stamp;
   sdtc_pkg::stamp_type    snapshot_stamp;
   sdtc_pkg::stage_en_type civil_en;

   logic                       target_ok4;
   logic                       snapshot_ok4;
   logic [sdtc_pkg::DAY_W-1:0] target_day4;
   logic [sdtc_pkg::DAY_W-1:0] snapshot_day4;
   logic [sdtc_pkg::DAY_W:0]   day_diff;
   logic                       skip_check;

   logic                       accepted_in,     accepted_ff;
   logic                       target_ok_in,    target_ok_ff;
   logic                       snapshot_ok_in,  snapshot_ok_ff;
   logic [sdtc_pkg::DAY_W-1:0] target_day_in,   target_day_ff;
   logic [sdtc_pkg::DAY_W-1:0] snapshot_day_in, snapshot_day_ff;

   // A stage loads when it is empty or the stage ahead of it loads this cycle.
   always_comb begin
      load[5] = !valid_ff[5] || rsp_ready;
      for (int k = 4; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[1] = load[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= 5; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_ready = load[1];
   assign civil_en  = {load[2], load[3], load[4]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Tolerance register: take every write, no handshake.
   assign tolerance_in = csr_write_enable ? csr_write_data : tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   // Stage 1: parse both stamps.
   sdtc_parse u_target_parse (
      .clock  (clock),
      .en     (load[1]),
      .chars  (req_target_chars),
      .length (req_target_length),
      .stamp  (target_stamp)
   );

   sdtc_parse u_snapshot_parse (
      .clock  (clock),
      .en     (load[1]),
      .chars  (req_snapshot_chars),
      .length (req_snapshot_length),
      .stamp  (snapshot_stamp)
   );

   // Stages 2 to 4: day numbers.
   sdtc_civil u_target_civil (
      .clock (clock),
      .en    (civil_en),
      .stamp (target_stamp),
      .ok    (target_ok4),
      .day   (target_day4)
   );

   sdtc_civil u_snapshot_civil (
      .clock (clock),
      .en    (civil_en),
      .stamp (snapshot_stamp),
      .ok    (snapshot_ok4),
      .day   (snapshot_day4)
   );

   // Stage 5: tolerance compare. Skip the check for a zero tolerance, a bad
   // stamp, a negative day number or a snapshot that is not newer; past
   // that point both days are non-negative and the difference is positive.
   always_comb begin
      day_diff   = {snapshot_day4[sdtc_pkg::DAY_W-1], snapshot_day4}
                 - {target_day4[sdtc_pkg::DAY_W-1], target_day4};
      skip_check = (tolerance_ff == '0) || !target_ok4 || !snapshot_ok4 ||
                   target_day4[sdtc_pkg::DAY_W-1] || snapshot_day4[sdtc_pkg::DAY_W-1] ||
                   ($signed(snapshot_day4) <= $signed(target_day4));
      accepted_in     = skip_check || (day_diff <= {2'b00, tolerance_ff});
      target_ok_in    = target_ok4;
      snapshot_ok_in  = snapshot_ok4;
      target_day_in   = target_day4;
      snapshot_day_in = snapshot_day4;
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         accepted_ff     <= accepted_in;
         target_ok_ff    <= target_ok_in;
         snapshot_ok_ff  <= snapshot_ok_in;
         target_day_ff   <= target_day_in;
         snapshot_day_ff <= snapshot_day_in;
      end
   end

   assign rsp_valid        = valid_ff[5];
   assign rsp_accepted     = accepted_ff;
   assign rsp_target_ok    = target_ok_ff;
   assign rsp_snapshot_ok  = snapshot_ok_ff;
   assign rsp_target_day   = $signed(target_day_ff);
   assign rsp_snapshot_day = $signed(snapshot_day_ff);

endmodule

`default_nettype wire

### rtl/core/sdtc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdtc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_accepted,
   input wire logic                              rsp_target_ok,
   input wire logic                              rsp_snapshot_ok,
   input wire logic signed [sdtc_pkg::DAY_W-1:0] rsp_target_day,
   input wire logic signed [sdtc_pkg::DAY_W-1:0] rsp_snapshot_day
);

   // A stalled response word holds.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted) &&
      $stable(rsp_target_ok) && $stable(rsp_snapshot_ok) &&
      $stable(rsp_target_day) && $stable(rsp_snapshot_day))
      else $error("response word changed while stalled");

   // The pipe is empty right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A bad stamp reports day zero and skips the check.
   a_target_bad : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_target_ok |-> rsp_target_day == '0 && rsp_accepted)
      else $error("bad target stamp with nonzero day or rejected");

   a_snapshot_bad : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_snapshot_ok |-> rsp_snapshot_day == '0 && rsp_accepted)
      else $error("bad snapshot stamp with nonzero day or rejected");

   // A snapshot that is not newer than its target is always taken.
   a_not_newer : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_snapshot_day <= rsp_target_day) |-> rsp_accepted)
      else $error("older snapshot rejected");

endmodule

bind snapshot_date_tolerance_check_core sdtc_checker u_sdtc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_accepted     (rsp_accepted),
   .rsp_target_ok    (rsp_target_ok),
   .rsp_snapshot_ok  (rsp_snapshot_ok),
   .rsp_target_day   (rsp_target_day),
   .rsp_snapshot_day (rsp_snapshot_day)
);

`default_nettype wire
